/* sv/assert_macros.svh */
// Assertion helpers shared by the gradient palette modules.
// Each helper samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/gpe_pkg.sv */
package gpe_pkg;

  // Field widths.
  localparam int ColorW = 8;
  localparam int PosW   = 9;
  localparam int RgbW   = 3 * ColorW;
  localparam int NumW   = 17;   // holds 255 * 511

  // Palette length; lookup indexes saturate to its last entry.
  localparam int TableSize = 256;

  // Action codes.
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MULT,
    ST_DIV,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // accept the transfer on the input ports
    logic scan;   // evaluate one checkpoint
    logic mult;   // form the weighted sums
    logic div;    // one quotient bit per channel
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // no checkpoints stored
    logic hit;       // current checkpoint closes the segment holding the entry
    logic last_pt;   // current checkpoint is the last stored one
    logic div_last;  // final division step
  } stat_t;

endpackage

/* sv/gpe_ctrl.sv */
module gpe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      action_i,
  input  gpe_pkg::stat_t  stat_i,
  output gpe_pkg::ctrl_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);
  import gpe_pkg::*;

  `include "assert_macros.svh"

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.take = 1'b1;
          if ((action_e'(action_i) == ACT_LOOKUP) && !stat_i.empty) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          state_d = ST_MULT;
        end else if (stat_i.last_pt) begin
          state_d = ST_DONE;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe held longer than one cycle")
  `ASSERT_NEXT(a_take_busy, start_i && !busy_o, busy_o, "accepted transfer did not raise busy")
  `ASSERT_NEXT(a_mult_div, state_q == ST_MULT, state_q == ST_DIV, "multiply not followed by divide")

endmodule

/* sv/gpe_datapath.sv */
module gpe_datapath #(
  parameter int MAX_POINTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gpe_pkg::ctrl_t              cmd_i,
  input  logic [1:0]                  action_i,
  input  logic [gpe_pkg::PosW-1:0]    position_i,
  input  logic [gpe_pkg::ColorW-1:0]  red_in_i,
  input  logic [gpe_pkg::ColorW-1:0]  green_in_i,
  input  logic [gpe_pkg::ColorW-1:0]  blue_in_i,
  output gpe_pkg::stat_t              stat_o,
  output logic [gpe_pkg::ColorW-1:0]  red_out_o,
  output logic [gpe_pkg::ColorW-1:0]  green_out_o,
  output logic [gpe_pkg::ColorW-1:0]  blue_out_o,
  output logic                        status_o
);
  import gpe_pkg::*;

  `include "assert_macros.svh"

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int EntW = PosW + RgbW;
  localparam int DenW = NumW;

  // Checkpoint store: position above colour, one entry per checkpoint.
  logic [EntW-1:0] mem_q [MAX_POINTS];
  logic [EntW-1:0] rd_q;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;

  logic [CW-1:0]   cnt_q;
  logic [IW-1:0]   idx_q;
  logic [PosW-1:0] k_q, start_q, d_q, n_q;
  logic [RgbW-1:0] run_q, c0_q, c1_q;
  logic [NumW-1:0] num_q [3];
  logic [NumW-1:0] num_d [3];
  logic [DenW-1:0] den_q;
  logic [ColorW-1:0] quo_q [3];
  logic [ColorW-1:0] quo_d [3];
  logic [2:0]      step_q;
  logic [ColorW-1:0] red_q, green_q, blue_q;
  logic            status_q;

  logic            full;
  action_e         act;
  logic [PosW-1:0] k_in;
  logic [PosW-1:0] pt_pos;
  logic [RgbW-1:0] pt_rgb;
  logic            adv;

  assign act    = action_e'(action_i);
  assign full   = cnt_q >= CW'(MAX_POINTS);
  assign wr_en  = cmd_i.take && (act == ACT_APPEND) && !full;
  assign k_in   = (32'(position_i) >= TableSize) ? PosW'(TableSize - 1) : position_i;
  assign pt_pos = rd_q[EntW-1:RgbW];
  assign pt_rgb = rd_q[RgbW-1:0];
  assign adv    = pt_pos > start_q;

  // The scan reads the next entry while it evaluates the current one.
  assign rd_addr = cmd_i.scan ? IW'(idx_q + IW'(1)) : '0;

  // Checkpoint memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IW-1:0]] <= {position_i, red_in_i, green_in_i, blue_in_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  // Status toward the controller.
  always_comb begin
    stat_o.empty    = cnt_q == '0;
    stat_o.hit      = adv && (k_q < pt_pos);
    stat_o.last_pt  = (CW'(idx_q) + CW'(1)) == cnt_q;
    stat_o.div_last = step_q == 3'd7;
  end

  // Checkpoint count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.take && (act == ACT_CLEAR)) begin
      cnt_q <= '0;
    end else if (wr_en) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Restoring division step, one quotient bit per channel. The quotient of a
  // convex mix never exceeds 255, so eight steps from d shifted by seven suffice.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (num_q[ch] >= den_q) begin
        num_d[ch] = num_q[ch] - den_q;
        quo_d[ch] = {quo_q[ch][ColorW-2:0], 1'b1};
      end else begin
        num_d[ch] = num_q[ch];
        quo_d[ch] = {quo_q[ch][ColorW-2:0], 1'b0};
      end
    end
  end

  // Scan, multiply and divide registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      k_q     <= k_in;
      start_q <= '0;
      run_q   <= '0;
      idx_q   <= '0;
    end
    if (cmd_i.scan) begin
      if (stat_o.hit) begin
        d_q  <= pt_pos - start_q;
        n_q  <= k_q - start_q;
        c0_q <= run_q;
        c1_q <= pt_rgb;
      end else begin
        if (adv) begin
          start_q <= pt_pos;
        end
        run_q <= pt_rgb;
        idx_q <= idx_q + IW'(1);
      end
    end
    if (cmd_i.mult) begin
      for (int ch = 0; ch < 3; ch++) begin
        num_q[ch] <= NumW'(c0_q[ch*ColorW +: ColorW]) * NumW'(d_q - n_q)
                   + NumW'(c1_q[ch*ColorW +: ColorW]) * NumW'(n_q);
        quo_q[ch] <= '0;
      end
      den_q  <= {1'b0, d_q, 7'b0};
      step_q <= '0;
    end
    if (cmd_i.div) begin
      for (int ch = 0; ch < 3; ch++) begin
        num_q[ch] <= num_d[ch];
        quo_q[ch] <= quo_d[ch];
      end
      den_q  <= den_q >> 1;
      step_q <= step_q + 3'd1;
    end
  end

  // Result registers; channel 2 is red, channel 0 is blue.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      status_q <= (act == ACT_APPEND) && full;
    end else if (cmd_i.scan && !stat_o.hit && stat_o.last_pt) begin
      red_q   <= pt_rgb[2*ColorW +: ColorW];
      green_q <= pt_rgb[ColorW +: ColorW];
      blue_q  <= pt_rgb[0 +: ColorW];
    end else if (cmd_i.div && stat_o.div_last) begin
      red_q   <= quo_d[2];
      green_q <= quo_d[1];
      blue_q  <= quo_d[0];
    end
  end

  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign status_o    = status_q;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(MAX_POINTS), "checkpoint count beyond table size")
  `ASSERT_NEXT(a_den_nonzero, cmd_i.mult, den_q != '0, "segment length of zero reached divider")

endmodule

/* sv/gradient_palette_expander.sv */
// Clear, append, unused code and empty-table lookup: the result transfer comes in the cycle
// after the transfer is accepted. A lookup first scans the stored checkpoints in order, from one
// up to MAX_POINTS of them; when the entry lies past the last checkpoint the result follows the
// scan, otherwise the multiply and the eight-step bit-serial divider come in between.
// Busy stays high through the result cycle, so a new transfer is taken in the cycle after it.
// Reset clears the checkpoint count and controller; the receiver cannot stall results.
module gradient_palette_expander #(
  parameter int MAX_POINTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [gpe_pkg::PosW-1:0]    position_i,
  input  logic [gpe_pkg::ColorW-1:0]  red_in_i,
  input  logic [gpe_pkg::ColorW-1:0]  green_in_i,
  input  logic [gpe_pkg::ColorW-1:0]  blue_in_i,
  output logic                        done_o,
  output logic [gpe_pkg::ColorW-1:0]  red_out_o,
  output logic [gpe_pkg::ColorW-1:0]  green_out_o,
  output logic [gpe_pkg::ColorW-1:0]  blue_out_o,
  output logic                        status_o
);
  import gpe_pkg::*;

  ctrl_t cmd;
  stat_t stat;

  // Sequencer.
  gpe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Checkpoint store, scan and interpolation.
  gpe_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .action_i    (action_i),
    .position_i  (position_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .stat_o      (stat),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .status_o    (status_o)
  );

endmodule
